// File: src/lpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lpa_pkg;

   localparam int MODE_W      = 2;
   localparam int NUMBER_W    = 5;
   localparam int STATUS_W    = 2;
   localparam int MAX_RESULTS = 32;
   localparam int COUNT_W     = $clog2(MAX_RESULTS);

   typedef enum logic [MODE_W-1:0] {
      MODE_ALLOC  = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_LIST   = 2'd2,
      MODE_UNUSED = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 2'd0,
      ST_EXHAUSTED  = 2'd1,
      ST_NOT_ACTIVE = 2'd2,
      ST_EMPTY      = 2'd3
   } status_type;

   // which address the active link memory reads in the next cycle
   typedef enum logic [1:0] {
      RD_HEAD = 2'd0,
      RD_CUR  = 2'd1,
      RD_NEXT = 2'd2
   } rd_sel_type;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [NUMBER_W-1:0] entry_number;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [NUMBER_W-1:0] result_number;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic       init_step;
      logic       start;
      logic       alloc_commit;
      logic       del_step;
      logic       del_commit;
      logic       list_emit;
      logic       emit_err;
      status_type err_code;
      rd_sel_type act_rd_sel;
   } cmd_type;

   typedef struct packed {
      logic init_last;
      logic free_empty;
      logic active_empty;
      logic match;
      logic next_none;
      logic count_last;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

// File: src/lpa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module lpa_datapath #(
   parameter int POOL_ENTRIES = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire lpa_pkg::cmd_type cmd,
   input  wire lpa_pkg::req_type req_data,
   output lpa_pkg::sts_type      sts,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output lpa_pkg::rsp_type      rsp_data
);

   localparam int LINK_W = $clog2(POOL_ENTRIES + 1);
   localparam int ADDR_W = $clog2(POOL_ENTRIES);
   localparam int CMP_W  = (LINK_W > lpa_pkg::NUMBER_W) ? LINK_W : lpa_pkg::NUMBER_W;
   localparam logic [LINK_W-1:0] NONE = LINK_W'(POOL_ENTRIES);
   localparam logic [ADDR_W-1:0] INIT_LAST = ADDR_W'(POOL_ENTRIES - 1);
   localparam logic [lpa_pkg::COUNT_W-1:0] COUNT_LAST =
      lpa_pkg::COUNT_W'(lpa_pkg::MAX_RESULTS - 1);

   logic [LINK_W-1:0] free_links_ff [POOL_ENTRIES];
   logic [LINK_W-1:0] active_links_ff [POOL_ENTRIES];
   logic [LINK_W-1:0] free_rd_ff;
   logic [LINK_W-1:0] act_rd_ff;

   logic [LINK_W-1:0] free_head_ff, free_head_in;
   logic [LINK_W-1:0] active_head_ff, active_head_in;
   logic [LINK_W-1:0] cur_ff, cur_in;
   logic [LINK_W-1:0] prev_ff, prev_in;
   logic [lpa_pkg::NUMBER_W-1:0] want_ff, want_in;
   logic [lpa_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] init_ff, init_in;
   logic              out_valid_ff, out_valid_in;
   lpa_pkg::rsp_type  out_data_ff, out_data_in;

   logic [LINK_W-1:0] act_rd_link;
   logic              free_we, act_we;
   logic [ADDR_W-1:0] free_wa, act_wa;
   logic [LINK_W-1:0] free_wd, act_wd;
   logic [CMP_W-1:0]  cur_wide, want_wide, free_head_wide;
   logic              out_free, load_out, list_last;

   assign cur_wide       = CMP_W'(cur_ff);
   assign want_wide      = CMP_W'(want_ff);
   assign free_head_wide = CMP_W'(free_head_ff);

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign list_last = (act_rd_ff == NONE) || (count_ff == COUNT_LAST);
   assign load_out  = cmd.emit_err || cmd.alloc_commit || cmd.del_commit || cmd.list_emit;

   always_comb begin
      sts.init_last    = (init_ff == INIT_LAST);
      sts.free_empty   = (free_head_ff == NONE);
      sts.active_empty = (active_head_ff == NONE);
      sts.match        = (cur_wide == want_wide);
      sts.next_none    = (act_rd_ff == NONE);
      sts.count_last   = (count_ff == COUNT_LAST);
      sts.out_free     = out_free;
   end

   always_comb begin
      case (cmd.act_rd_sel)
         lpa_pkg::RD_CUR:  act_rd_link = cur_ff;
         lpa_pkg::RD_NEXT: act_rd_link = act_rd_ff;
         default:          act_rd_link = active_head_ff;
      endcase
   end

   // single write port per memory
   always_comb begin
      free_we = 1'b0;
      free_wa = init_ff;
      free_wd = LINK_W'(init_ff) + LINK_W'(1);
      act_we  = 1'b0;
      act_wa  = init_ff;
      act_wd  = NONE;
      if (cmd.init_step) begin
         free_we = 1'b1;
         act_we  = 1'b1;
      end
      if (cmd.alloc_commit) begin
         act_we = 1'b1;
         act_wa = free_head_ff[ADDR_W-1:0];
         act_wd = active_head_ff;
      end
      if (cmd.del_commit) begin
         free_we = 1'b1;
         free_wa = cur_ff[ADDR_W-1:0];
         free_wd = free_head_ff;
         // unlink from the predecessor unless the entry was the head
         if (prev_ff != NONE) begin
            act_we = 1'b1;
            act_wa = prev_ff[ADDR_W-1:0];
            act_wd = act_rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (free_we) begin
         free_links_ff[free_wa] <= free_wd;
      end
      free_rd_ff <= free_links_ff[free_head_ff[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (act_we) begin
         active_links_ff[act_wa] <= act_wd;
      end
      act_rd_ff <= active_links_ff[act_rd_link[ADDR_W-1:0]];
   end

   always_comb begin
      free_head_in   = free_head_ff;
      active_head_in = active_head_ff;
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      want_in        = want_ff;
      count_in       = count_ff;
      init_in        = init_ff;
      if (cmd.init_step) begin
         init_in = init_ff + ADDR_W'(1);
      end
      if (cmd.start) begin
         cur_in   = active_head_ff;
         prev_in  = NONE;
         want_in  = req_data.entry_number;
         count_in = '0;
      end
      if (cmd.alloc_commit) begin
         free_head_in   = free_rd_ff;
         active_head_in = free_head_ff;
      end
      if (cmd.del_step) begin
         prev_in = cur_ff;
         cur_in  = act_rd_ff;
      end
      if (cmd.del_commit) begin
         free_head_in = cur_ff;
         if (prev_ff == NONE) begin
            active_head_in = act_rd_ff;
         end
      end
      if (cmd.list_emit) begin
         cur_in   = act_rd_ff;
         count_in = count_ff + lpa_pkg::COUNT_W'(1);
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      out_data_in  = out_data_ff;
      if (load_out) begin
         out_valid_in              = 1'b1;
         out_data_in.status        = lpa_pkg::ST_OK;
         out_data_in.result_number = cur_wide[lpa_pkg::NUMBER_W-1:0];
         out_data_in.last          = 1'b1;
         if (cmd.emit_err) begin
            out_data_in.status        = cmd.err_code;
            out_data_in.result_number = '0;
         end else if (cmd.alloc_commit) begin
            out_data_in.result_number = free_head_wide[lpa_pkg::NUMBER_W-1:0];
         end else if (cmd.list_emit) begin
            out_data_in.last = list_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff   <= '0;
         active_head_ff <= NONE;
         init_ff        <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         free_head_ff   <= free_head_in;
         active_head_ff <= active_head_in;
         init_ff        <= init_in;
         out_valid_ff   <= out_valid_in;
      end
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      want_ff     <= want_in;
      count_ff    <= count_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   a_out_slot_free: assert property (@(posedge clock) disable iff (reset)
      load_out |-> out_free)
      else $error("result loaded while the output register is still occupied");

   a_heads_disjoint: assert property (@(posedge clock) disable iff (reset)
      (free_head_ff != active_head_ff) || (free_head_ff == NONE))
      else $error("one entry heads both the free and the active list");

endmodule

`default_nettype wire

// File: src/lpa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lpa_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire lpa_pkg::req_type req_data,
   input  wire lpa_pkg::sts_type sts,
   output lpa_pkg::cmd_type      cmd
);

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_ALLOC,
      S_DEL,
      S_LIST
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.err_code   = lpa_pkg::ST_OK;
      cmd.act_rd_sel = lpa_pkg::RD_HEAD;
      req_stall      = 1'b1;
      unique case (state_ff)
         S_INIT: begin
            cmd.init_step = 1'b1;
            if (sts.init_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_stall = !sts.out_free;
            if (req_valid && sts.out_free) begin
               unique case (req_data.mode)
                  lpa_pkg::MODE_ALLOC: begin
                     if (sts.free_empty) begin
                        cmd.emit_err = 1'b1;
                        cmd.err_code = lpa_pkg::ST_EXHAUSTED;
                     end else begin
                        state_in = S_ALLOC;
                     end
                  end
                  lpa_pkg::MODE_DELETE: begin
                     cmd.start = 1'b1;
                     if (sts.active_empty) begin
                        cmd.emit_err = 1'b1;
                        cmd.err_code = lpa_pkg::ST_NOT_ACTIVE;
                     end else begin
                        state_in = S_DEL;
                     end
                  end
                  lpa_pkg::MODE_LIST: begin
                     cmd.start = 1'b1;
                     if (sts.active_empty) begin
                        cmd.emit_err = 1'b1;
                        cmd.err_code = lpa_pkg::ST_EMPTY;
                     end else begin
                        state_in = S_LIST;
                     end
                  end
                  default: begin
                     // unused mode: request dropped without a result
                  end
               endcase
            end
         end
         S_ALLOC: begin
            cmd.alloc_commit = 1'b1;
            state_in         = S_IDLE;
         end
         S_DEL: begin
            if (sts.match) begin
               cmd.del_commit = 1'b1;
               state_in       = S_IDLE;
            end else if (sts.next_none) begin
               cmd.emit_err = 1'b1;
               cmd.err_code = lpa_pkg::ST_NOT_ACTIVE;
               state_in     = S_IDLE;
            end else begin
               cmd.del_step   = 1'b1;
               cmd.act_rd_sel = lpa_pkg::RD_NEXT;
            end
         end
         S_LIST: begin
            if (sts.out_free) begin
               cmd.list_emit  = 1'b1;
               cmd.act_rd_sel = lpa_pkg::RD_NEXT;
               if (sts.next_none || sts.count_last) begin
                  state_in = S_IDLE;
               end
            end else begin
               // hold the read on the current entry while the output waits
               cmd.act_rd_sel = lpa_pkg::RD_CUR;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   a_alloc_has_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ALLOC) |-> !sts.free_empty)
      else $error("allocate commit with an empty free list");

   a_walk_list_present: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DEL || state_ff == S_LIST) |-> !sts.active_empty)
      else $error("active list walk started on an empty list");

endmodule

`default_nettype wire

// File: src/linked_pool_allocator.sv
// Pool allocator over POOL_ENTRIES numbered entries kept on a LIFO free list and an
// active list, both held as link memories with one write and one registered read
// port each. After reset the block sweeps both link memories, one entry per cycle,
// with req_stall high. An allocate request passes through the S_ALLOC state, which
// uses the registered read of the free link memory. A delete request walks the
// active list from the head, one link per cycle, until it finds the number or
// reaches the end; a number that is not active walks the whole list. A list
// request gives n results (at most 32), one link per cycle while the output
// register is free; rsp_stall holding the output register holds the walk. A
// request with a status-only outcome because the pool or the list is empty is
// answered from the idle state. A result waits in an output register, and the
// next request is taken while that register drains.
`timescale 1ns / 1ps
`default_nettype none

module linked_pool_allocator #(
   parameter int POOL_ENTRIES = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire lpa_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output lpa_pkg::rsp_type      rsp_data
);

   lpa_pkg::cmd_type cmd;
   lpa_pkg::sts_type sts;

   lpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .sts       (sts),
      .cmd       (cmd)
   );

   lpa_datapath #(
      .POOL_ENTRIES (POOL_ENTRIES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: verif/lpa_list_checker.sv
`timescale 1ns / 1ps

module lpa_list_checker
   import lpa_pkg::*;
#(
   parameter int POOL_ENTRIES = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      outstanding
);

   localparam logic [5:0] NO_ENTRY = 6'(POOL_ENTRIES);

   // shadow copy of both link memories and their heads
   logic [5:0] free_link [POOL_ENTRIES];
   logic [5:0] active_link [POOL_ENTRIES];
   logic [5:0] free_head;
   logic [5:0] active_head;

   rsp_type pending_results[$];
   rsp_type oldest;

   function automatic void queue_result(status_type s, logic [4:0] num, logic fin);
      pending_results.push_back('{status: s, result_number: num, last: fin});
   endfunction

   task automatic model_request(input req_type r);
      logic [5:0] cur;
      logic [5:0] prev;
      logic [5:0] nxt;
      int steps;
      bit found;
      case (mode_type'(r.mode))
         MODE_ALLOC: begin
            if (free_head == NO_ENTRY) begin
               queue_result(ST_EXHAUSTED, '0, 1'b1);
            end else begin
               cur = free_head;
               free_head = free_link[cur];
               active_link[cur] = active_head;
               active_head = cur;
               queue_result(ST_OK, cur[4:0], 1'b1);
            end
         end
         MODE_DELETE: begin
            prev = NO_ENTRY;
            cur = active_head;
            steps = 0;
            found = 1'b0;
            while (cur != NO_ENTRY && steps < POOL_ENTRIES && !found) begin
               if (cur[4:0] == r.entry_number) begin
                  found = 1'b1;
                  nxt = active_link[cur];
                  if (prev == NO_ENTRY) begin
                     active_head = nxt;
                  end else begin
                     active_link[prev] = nxt;
                  end
                  active_link[cur] = NO_ENTRY;
                  free_link[cur] = free_head;
                  free_head = cur;
                  queue_result(ST_OK, cur[4:0], 1'b1);
               end else begin
                  prev = cur;
                  cur = active_link[cur];
                  steps++;
               end
            end
            if (!found) begin
               queue_result(ST_NOT_ACTIVE, '0, 1'b1);
            end
         end
         MODE_LIST: begin
            if (active_head == NO_ENTRY) begin
               queue_result(ST_EMPTY, '0, 1'b1);
            end else begin
               cur = active_head;
               steps = 0;
               while (cur != NO_ENTRY && steps < MAX_RESULTS) begin
                  nxt = active_link[cur];
                  queue_result(ST_OK, cur[4:0], nxt == NO_ENTRY || steps + 1 == MAX_RESULTS);
                  cur = nxt;
                  steps++;
               end
            end
         end
         default: begin
            // unused mode gives nothing back
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < POOL_ENTRIES; i++) begin
            free_link[i] = 6'(i + 1);
            active_link[i] = NO_ENTRY;
         end
         free_head = '0;
         active_head = NO_ENTRY;
         pending_results.delete();
      end else begin
         // results first, so a request taken on the same edge cannot satisfy them
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("result with nothing awaited: status %0d, number %0d, last %0d",
                      rsp_data.status, rsp_data.result_number, rsp_data.last);
               fail_count++;
            end else begin
               oldest = pending_results.pop_front();
               if (rsp_data.status !== oldest.status) begin
                  $error("status: expected %0d, got %0d", oldest.status, rsp_data.status);
                  fail_count++;
               end
               if (rsp_data.result_number !== oldest.result_number) begin
                  $error("result_number: expected %0d, got %0d",
                         oldest.result_number, rsp_data.result_number);
                  fail_count++;
               end
               if (rsp_data.last !== oldest.last) begin
                  $error("last: expected %0d, got %0d", oldest.last, rsp_data.last);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            model_request(req_data);
         end
      end
      outstanding = pending_results.size();
   end

endmodule

// File: verif/tb_linked_pool_allocator.sv
`timescale 1ns / 1ps

module tb_linked_pool_allocator;
   import lpa_pkg::*;

   localparam int POOL_ENTRIES = 32;
   localparam int ITEM_TARGET  = 210;
   localparam int IDLE_LIMIT   = 2000;
   localparam int SETTLE       = 40;
   localparam int LONG_HOLD    = 150;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int fail_count;
   int outstanding;
   int request_count = 0;
   int ignored_count = 0;
   int mode_count [3] = '{0, 0, 0};
   int status_count [4] = '{0, 0, 0, 0};
   int idle_cycles = 0;
   bit send_quiet = 1'b0;

   linked_pool_allocator #(.POOL_ENTRIES(POOL_ENTRIES)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   lpa_list_checker #(.POOL_ENTRIES(POOL_ENTRIES)) list_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // watchdog on handshake progress, plus a tally of result statuses
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         status_count[rsp_data.status] <= status_count[rsp_data.status] + 1;
      end
   end

   // result side: random hold-offs, quiet stretches and one long hold
   initial begin : result_sink
      int hold;
      int taken;
      bit quiet;
      bit held;
      taken = 0;
      quiet = 1'b0;
      held = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 15) == 0) begin
            quiet = !quiet;
         end
         if (!held && taken >= 60 && req_valid) begin
            hold = LONG_HOLD;
            held = 1'b1;
         end else begin
            hold = quiet ? 0 : $urandom_range(0, 8);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
         taken++;
      end
   end

   task automatic send_request(input mode_type m, input logic [4:0] num);
      int gap;
      gap = send_quiet ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_data <= req_type'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{mode: m, entry_number: num};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (m == MODE_UNUSED) begin
         ignored_count++;
      end else begin
         request_count++;
         mode_count[m]++;
      end
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      int order [POOL_ENTRIES];
      int pick;
      int swap_idx;
      int tmp;
      int episodes;
      int r;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // empty list behaviour, ignored mode, then a small list worked by hand
      send_request(MODE_LIST, 5'd31);
      send_request(MODE_DELETE, 5'd0);
      send_request(MODE_DELETE, 5'd31);
      send_request(MODE_UNUSED, 5'd31);
      repeat (4) send_request(MODE_ALLOC, 5'($urandom));
      send_request(MODE_LIST, 5'd0);
      send_request(MODE_DELETE, 5'd2);
      send_request(MODE_DELETE, 5'd0);
      send_request(MODE_DELETE, 5'd3);
      send_request(MODE_DELETE, 5'd2);
      send_request(MODE_UNUSED, 5'd0);
      send_request(MODE_LIST, 5'd31);
      send_request(MODE_ALLOC, 5'd0);
      send_request(MODE_LIST, 5'd10);

      episodes = 0;
      while (request_count < ITEM_TARGET) begin
         send_quiet = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 9);
         if (pick < 3) begin
            // fill past exhaustion, then a full-length list
            repeat (33 + $urandom_range(0, 2)) send_request(MODE_ALLOC, 5'($urandom));
            send_request(MODE_LIST, 5'($urandom));
         end else if (pick < 5) begin
            // delete every number in shuffled order, then list the empty active list
            for (int i = 0; i < POOL_ENTRIES; i++) begin
               order[i] = i;
            end
            for (int i = POOL_ENTRIES - 1; i > 0; i--) begin
               swap_idx = $urandom_range(0, i);
               tmp = order[i];
               order[i] = order[swap_idx];
               order[swap_idx] = tmp;
            end
            for (int i = 0; i < POOL_ENTRIES; i++) begin
               send_request(MODE_DELETE, 5'(order[i]));
            end
            send_request(MODE_LIST, 5'($urandom));
         end else begin
            repeat (12) begin
               r = $urandom_range(0, 9);
               if (r <= 3) begin
                  send_request(MODE_ALLOC, 5'($urandom));
               end else if (r <= 7) begin
                  send_request(MODE_DELETE, 5'($urandom));
               end else if (r == 8) begin
                  send_request(MODE_LIST, 5'($urandom));
               end else begin
                  send_request(MODE_UNUSED, 5'($urandom));
               end
            end
         end
         episodes++;
         if (episodes == 1 || $urandom_range(0, 3) == 0) begin
            drain_results();
         end
      end

      drain_results();
      repeat (SETTLE) @(negedge clock);
      $display("covered %0d allocate, %0d delete and %0d list requests, %0d in the unused mode",
               mode_count[MODE_ALLOC], mode_count[MODE_DELETE], mode_count[MODE_LIST],
               ignored_count);
      $display("results: %0d ok, %0d pool exhausted, %0d not active, %0d empty list",
               status_count[ST_OK], status_count[ST_EXHAUSTED], status_count[ST_NOT_ACTIVE],
               status_count[ST_EMPTY]);
      if (fail_count == 0 && outstanding == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: files.f
src/lpa_pkg.sv
src/lpa_datapath.sv
src/lpa_ctrl.sv
src/linked_pool_allocator.sv
verif/lpa_list_checker.sv
verif/tb_linked_pool_allocator.sv
